>>> rtl/dia_pkg.sv
// dia_pkg: shared types and constants of the descriptor index allocator.
// No dependencies; imported by every allocator module.
`default_nettype none

package dia_pkg;

  localparam int unsigned SLOT_W   = 10;  // slot index carried by items
  localparam int unsigned COUNT_W  = 11;  // slot count register, bump counter
  localparam int unsigned STRIDE_W = 12;
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned OFF_W    = COUNT_W + STRIDE_W;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_IGNORED = 2'd2,
    STATUS_DROPPED = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_COUNT     = 3'd0,
    REG_SHADER_VISIBLE = 3'd1,
    REG_SLOT_STRIDE    = 3'd2,
    REG_CPU_BASE       = 3'd3,
    REG_GPU_BASE       = 3'd4
  } cfg_reg_t;

  localparam logic [COUNT_W-1:0]  SLOT_COUNT_RST  = 11'd1024;
  localparam logic [STRIDE_W-1:0] SLOT_STRIDE_RST = 12'd32;

  typedef struct packed {
    logic [COUNT_W-1:0]  slot_count;
    logic                shader_visible;
    logic [STRIDE_W-1:0] slot_stride;
    logic [ADDR_W-1:0]   cpu_base;
    logic [ADDR_W-1:0]   gpu_base;
  } cfg_t;

  // Outcome of the free-list stage for one item.
  typedef struct packed {
    logic               valid;
    logic               ok;         // a slot was handed out
    logic               from_fifo;  // index comes from the fifo read data
    logic [COUNT_W-1:0] bump_idx;
    status_t            status;
  } grant_t;

endpackage

`default_nettype wire

>>> rtl/dia_cfg_regs.sv
// dia_cfg_regs: configuration register file of the allocator.
// Depends on dia_pkg.
`default_nettype none

module dia_cfg_regs
  import dia_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [ADDR_W-1:0]    wr_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slot_count     <= SLOT_COUNT_RST;
      cfg.shader_visible <= 1'b0;
      cfg.slot_stride    <= SLOT_STRIDE_RST;
      cfg.cpu_base       <= '0;
      cfg.gpu_base       <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SLOT_COUNT:     cfg.slot_count     <= wr_data[COUNT_W-1:0];
        REG_SHADER_VISIBLE: cfg.shader_visible <= wr_data[0];
        REG_SLOT_STRIDE:    cfg.slot_stride    <= wr_data[STRIDE_W-1:0];
        REG_CPU_BASE:       cfg.cpu_base       <= wr_data;
        REG_GPU_BASE:       cfg.gpu_base       <= wr_data;
        default: ;  // unmapped index: write has no effect
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/dia_free_list.sv
// dia_free_list: fifo of freed indices plus bump counter; decides each item.
// Depends on dia_pkg.
`default_nettype none

module dia_free_list
  import dia_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wire logic               action,
  input  wire logic [SLOT_W-1:0]  free_slot,
  input  wire logic               handle_valid,
  input  wire logic [COUNT_W-1:0] slot_count,
  output grant_t                  grant,
  output logic [SLOT_W-1:0]       rd_data
);

  localparam int unsigned PTR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_SLOTS - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SLOTS);

  logic [SLOT_W-1:0]  mem [MAX_SLOTS];
  logic [PTR_W-1:0]   head, tail;
  logic [CNT_W-1:0]   count;
  logic [COUNT_W-1:0] next_unused;

  logic   push, pop, bump, bump_full;
  grant_t grant_next;

  // bump counter stops at the smaller of slot_count and MAX_SLOTS
  assign bump_full = (next_unused >= slot_count) || (32'(next_unused) >= 32'(MAX_SLOTS));

  always_comb begin
    push = 1'b0;
    pop  = 1'b0;
    bump = 1'b0;
    grant_next           = '0;
    grant_next.valid     = take;
    grant_next.bump_idx  = next_unused;
    grant_next.status    = STATUS_OK;
    if (action) begin
      if (!handle_valid) begin
        grant_next.status = STATUS_IGNORED;
      end else if (count == CNT_FULL) begin
        grant_next.status = STATUS_DROPPED;
      end else begin
        push = take;
      end
    end else if (count != '0) begin
      pop                  = take;
      grant_next.ok        = 1'b1;
      grant_next.from_fifo = 1'b1;
    end else if (bump_full) begin
      grant_next.status = STATUS_FULL;
    end else begin
      bump          = take;
      grant_next.ok = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    grant.ok        <= grant_next.ok;
    grant.from_fifo <= grant_next.from_fifo;
    grant.bump_idx  <= grant_next.bump_idx;
    grant.status    <= grant_next.status;
    if (rst) begin
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      next_unused <= '0;
      grant.valid <= 1'b0;
    end else begin
      grant.valid <= grant_next.valid;
      if (push) begin
        tail  <= (tail == PTR_LAST) ? '0 : tail + 1'b1;
        count <= count + 1'b1;
      end
      if (pop) begin
        head  <= (head == PTR_LAST) ? '0 : head + 1'b1;
        count <= count - 1'b1;
      end
      if (bump) begin
        next_unused <= next_unused + 1'b1;
      end
    end
  end

  // single port memory: push and pop never fall in the same cycle
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= free_slot;
    end
    if (pop) begin
      rd_data <= mem[head];
    end
  end

endmodule

`default_nettype wire

>>> rtl/dia_addr_gen.sv
// dia_addr_gen: index times stride, then base add, into the result register.
// Depends on dia_pkg.
`default_nettype none

module dia_addr_gen
  import dia_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire grant_t            grant,
  input  wire logic [SLOT_W-1:0] rd_data,
  input  wire cfg_t              cfg,
  output logic                   done,
  output logic [SLOT_W-1:0]      slot_index,
  output logic [ADDR_W-1:0]      cpu_address,
  output logic [ADDR_W-1:0]      gpu_address,
  output status_t                status
);

  logic [COUNT_W-1:0] idx;
  logic [OFF_W-1:0]   off_next;

  logic               valid2;
  logic               ok2;
  logic [SLOT_W-1:0]  idx2;
  logic [OFF_W-1:0]   off2;
  status_t            status2;

  assign idx      = grant.from_fifo ? COUNT_W'(rd_data) : grant.bump_idx;
  assign off_next = OFF_W'(idx) * OFF_W'(cfg.slot_stride);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      valid2 <= grant.valid;
      done   <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    ok2     <= grant.ok;
    idx2    <= idx[SLOT_W-1:0];
    off2    <= off_next;
    status2 <= grant.status;
  end

  always_ff @(posedge clk) begin
    status <= status2;
    if (ok2) begin
      slot_index  <= idx2;
      cpu_address <= cfg.cpu_base + ADDR_W'(off2);
      gpu_address <= cfg.shader_visible ? cfg.gpu_base + ADDR_W'(off2) : '0;
    end else begin
      slot_index  <= '0;
      cpu_address <= '0;
      gpu_address <= '0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/descriptor_index_allocator.sv
// descriptor_index_allocator: top level of the descriptor slot allocator.
// Depends on dia_pkg, dia_cfg_regs, dia_free_list, dia_addr_gen.
//
//  channel   | handshake                        | payload
//  ----------+----------------------------------+------------------------------------
//  request   | start, busy (taken: start&!busy) | action, free_slot, handle_valid
//  result    | done (one-cycle strobe)          | slot_index, cpu_address,
//            |                                  | gpu_address, status
//  config    | cfg_valid, cfg_ready             | cfg_index, cfg_data
//
// One item is taken per cycle while busy is low; each result follows its item through the stages below.
// Stage 1 is the free-list decision with the registered fifo memory read,
// stage 2 the index-times-stride multiply, stage 3 the base add and result.
// busy is high only while rst is high; no clearing pass follows reset since
// the fifo is only read at entries already written.
// The receiver cannot stall: done is a plain strobe and nothing waits on it.
// Config writes are always ready and belong in idle periods only.
`default_nettype none

module descriptor_index_allocator
  import dia_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // request
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 action,
  input  wire logic [SLOT_W-1:0]    free_slot,
  input  wire logic                 handle_valid,
  // result
  output logic                      done,
  output logic [SLOT_W-1:0]         slot_index,
  output logic [ADDR_W-1:0]         cpu_address,
  output logic [ADDR_W-1:0]         gpu_address,
  output logic [1:0]                status,
  // config
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data
);

  cfg_t              cfg;
  grant_t            grant;
  logic [SLOT_W-1:0] rd_data;
  status_t           status_q;
  logic              take;

  assign busy      = rst;   // pipeline takes an item every cycle outside reset
  assign cfg_ready = 1'b1;
  assign take      = start & ~busy;
  assign status    = status_q;

  dia_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  dia_free_list #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_free_list (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .action       (action),
    .free_slot    (free_slot),
    .handle_valid (handle_valid),
    .slot_count   (cfg.slot_count),
    .grant        (grant),
    .rd_data      (rd_data)
  );

  dia_addr_gen u_addr (
    .clk         (clk),
    .rst         (rst),
    .grant       (grant),
    .rd_data     (rd_data),
    .cfg         (cfg),
    .done        (done),
    .slot_index  (slot_index),
    .cpu_address (cpu_address),
    .gpu_address (gpu_address),
    .status      (status_q)
  );

endmodule

`default_nettype wire

>>> rtl/dia_checker.sv
// dia_checker: port-level checks of the allocator's result timing and contents.
// Depends on dia_pkg; bound to descriptor_index_allocator.
`default_nettype none

module dia_checker
  import dia_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              action,
  input wire logic              done,
  input wire logic [SLOT_W-1:0] slot_index,
  input wire logic [ADDR_W-1:0] cpu_address,
  input wire logic [ADDR_W-1:0] gpu_address,
  input wire logic [1:0]        status
);

  // every item taken gives a result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("item without result");

  // no result without an earlier item
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without item");

  // results with a status other than OK carry zero payload
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (done && status != STATUS_OK) |->
      (slot_index == '0 && cpu_address == '0 && gpu_address == '0))
    else $error("nonzero payload on non-allocation");

  // free-only codes come from frees, heap full from allocations
  a_status_kind: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STATUS_IGNORED || status == STATUS_DROPPED)) |->
      $past(action, 3))
    else $error("free status on allocation");

  a_full_kind: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_FULL) |-> !$past(action, 3))
    else $error("heap full on free");

endmodule

bind descriptor_index_allocator dia_checker u_dia_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .action      (action),
  .done        (done),
  .slot_index  (slot_index),
  .cpu_address (cpu_address),
  .gpu_address (gpu_address),
  .status      (status)
);

`default_nettype wire
